@@ rtl/core/rde_pkg.sv @@
// Shared types and constants for the raster draw engine.
// No dependencies.
package rde_pkg;
  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 64;
  localparam logic [2:0] WHITE = 3'd4;
  localparam int CNT_W = 12;

  typedef enum logic [1:0] {
    K_LINE = 2'd0,
    K_FILL = 2'd1,
    K_COPY = 2'd2,
    K_READ = 2'd3
  } kind_t;
endpackage

@@ rtl/core/rde_mem.sv @@
// Canvas and snapshot memories, each with a registered read.
// No dependencies.
module rde_mem #(
  parameter int CELLS = 2048,
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          cwe,
  input  logic [AW-1:0] cwaddr,
  input  logic [2:0]    cwdata,
  input  logic [AW-1:0] craddr,
  output logic [2:0]    crdata,
  input  logic          swe,
  input  logic [AW-1:0] swaddr,
  input  logic [2:0]    swdata,
  input  logic [AW-1:0] sraddr,
  output logic [2:0]    srdata
);
  logic [2:0] canvas [CELLS];
  logic [2:0] snap [CELLS];

  always_ff @(posedge clk) begin
    if (cwe) begin
      canvas[cwaddr] <= cwdata;
    end
    crdata <= canvas[craddr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      snap[swaddr] <= swdata;
    end
    srdata <= snap[sraddr];
  end
endmodule

@@ rtl/core/raster_draw_engine_core.sv @@
// Top level of the raster draw engine: command sequencer over the canvas memory.
// Depends on rde_pkg and rde_mem.
//
// Usage: one command beat on s_axis (kind on tuser; corners, target, shade on
// tdata) yields one result beat on m_axis (pixel_shade, pixels_written). One
// command at a time.
// After reset a clearing pass writes white to all ROWS*COLS cells, one per
// cycle (2048 cells at default size); s_axis_tready stays low meanwhile.
// Line walks every point between its ends if the line is horizontal, vertical
// or diagonal (any other line draws nothing), fill every cell of the clipped
// rectangle, one cell per cycle.
// Copy first runs a snapshot pass (one read and one write per cycle through
// the canvas read port), then walks the source rectangle clipped to the
// canvas, one cell per cycle with the registered snapshot read overlapped.
// A read pixel result passes the S_READ and S_OUT states before it is valid.
// The result sits in an output register until taken; the engine waits for it
// to drain before the next command, so a stalled receiver holds the engine.
module raster_draw_engine_core #(
  parameter int ROWS = rde_pkg::ROWS_DEF,
  parameter int COLS = rde_pkg::COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // first_row[7:0], first_col[15:8], last_row[23:16], last_col[31:24],
  // dest_row[39:32], dest_col[47:40], shade[50:48], zero pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_shade[2:0], pixels_written[14:3], zero pad
  output logic [15:0] m_axis_tdata
);
  localparam int CELLS = ROWS * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(COLS);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_WALK, S_SNAP, S_COPY, S_READ, S_OUT
  } state_t;

  state_t state;
  logic [1:0] kind;
  logic signed [9:0] r, c, rend, cend, top, lft, tr, tc;
  logic signed [9:0] dr, dc;
  logic [2:0] shade;
  logic [AW:0] ptr;
  logic [11:0] cnt;
  logic [2:0] pix;
  logic pend;
  logic [AW-1:0] pend_addr;
  logic [AW-1:0] rowaddr;

  logic cwe, swe;
  logic [AW-1:0] cwaddr, craddr, swaddr;
  logic [2:0] cwdata, crdata, srdata;

  rde_mem #(.CELLS(CELLS), .AW(AW)) u_mem (
    .clk, .cwe, .cwaddr, .cwdata, .craddr, .crdata,
    .swe, .swaddr, .swdata(crdata), .sraddr(craddr), .srdata
  );

  function automatic logic [AW-1:0] addr_of(logic signed [9:0] rr, logic signed [9:0] cc);
    logic [AW+CW:0] a;
    a = (AW+CW+1)'(rr[7:0]) * (AW+CW+1)'(COLS) + (AW+CW+1)'(cc[7:0]);
    return a[AW-1:0];
  endfunction

  function automatic logic on_cv(logic signed [9:0] rr, logic signed [9:0] cc);
    return rr >= 0 && rr < 10'(ROWS) && cc >= 0 && cc < 10'(COLS);
  endfunction

  logic signed [9:0] i_r0, i_c0, i_r1, i_c1;
  logic signed [9:0] ddr, ddc, adr, adc;
  assign i_r0 = 10'(signed'(s_axis_tdata[7:0]));
  assign i_c0 = 10'(signed'(s_axis_tdata[15:8]));
  assign i_r1 = 10'(signed'(s_axis_tdata[23:16]));
  assign i_c1 = 10'(signed'(s_axis_tdata[31:24]));
  assign ddr = i_r1 - i_r0;
  assign ddc = i_c1 - i_c0;
  assign adr = ddr < 0 ? -ddr : ddr;
  assign adc = ddc < 0 ? -ddc : ddc;

  // target of current copy source cell
  logic signed [9:0] trr, tcc;
  assign trr = tr + (r - top);
  assign tcc = tc + (c - lft);

  assign s_axis_tready = (state == S_IDLE);
  assign rowaddr = addr_of(r, c);

  always_comb begin
    cwe = 1'b0;
    cwaddr = addr_of(r, c);
    cwdata = shade;
    craddr = addr_of(r, c);
    swe = 1'b0;
    swaddr = pend_addr;
    case (state)
      S_CLR: begin
        cwe = 1'b1;
        cwaddr = ptr[AW-1:0];
        cwdata = rde_pkg::WHITE;
      end
      S_IDLE: craddr = addr_of(i_r0, i_c0);
      S_WALK: cwe = on_cv(r, c);
      S_SNAP: begin
        craddr = ptr[AW-1:0];
        swe = pend;
      end
      S_COPY: begin
        cwe = pend;
        cwaddr = pend_addr;
        cwdata = srdata;
        craddr = rowaddr;
      end
      default: ;
    endcase
  end

  logic walk_done;
  assign walk_done = (r == rend) && (c == cend);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ptr <= '0;
      m_axis_tvalid <= 1'b0;
      pend <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          ptr <= ptr + 1'b1;
          if (ptr == (AW+1)'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          kind <= s_axis_tuser;
          shade <= (s_axis_tdata[50:48] > rde_pkg::WHITE) ? rde_pkg::WHITE
                                                          : s_axis_tdata[50:48];
          tr <= 10'(signed'(s_axis_tdata[39:32]));
          tc <= 10'(signed'(s_axis_tdata[47:40]));
          cnt <= '0;
          pix <= '0;
          ptr <= '0;
          pend <= 1'b0;
          case (rde_pkg::kind_t'(s_axis_tuser))
            rde_pkg::K_LINE: begin
              r <= i_r0; c <= i_c0; rend <= i_r1; cend <= i_c1;
              dr <= ddr > 0 ? 10'sd1 : (ddr < 0 ? -10'sd1 : 10'sd0);
              dc <= ddc > 0 ? 10'sd1 : (ddc < 0 ? -10'sd1 : 10'sd0);
              state <= (ddr == 0 || ddc == 0 || adr == adc) ? S_WALK : S_OUT;
            end
            rde_pkg::K_FILL, rde_pkg::K_COPY: begin
              logic signed [9:0] t, b, lo, hi;
              t = i_r0 < i_r1 ? i_r0 : i_r1;
              b = i_r0 < i_r1 ? i_r1 : i_r0;
              lo = i_c0 < i_c1 ? i_c0 : i_c1;
              hi = i_c0 < i_c1 ? i_c1 : i_c0;
              top <= t; lft <= lo;
              // clip walked span; copy target offsets use unclipped top/left
              if (t < 0) t = '0;
              if (lo < 0) lo = '0;
              if (b > 10'(ROWS - 1)) b = 10'(ROWS - 1);
              if (hi > 10'(COLS - 1)) hi = 10'(COLS - 1);
              r <= t; c <= lo; rend <= b; cend <= hi;
              dr <= 10'sd0; dc <= 10'sd1;
              if (t > b || lo > hi) state <= S_OUT;
              else if (s_axis_tuser == rde_pkg::K_FILL) state <= S_WALK;
              else state <= S_SNAP;
            end
            default: begin
              r <= i_r0; c <= i_c0;
              state <= S_READ;
            end
          endcase
        end
        S_WALK: begin
          if (on_cv(r, c)) cnt <= cnt + 1'b1;
          if (walk_done) state <= S_OUT;
          else if (kind == rde_pkg::K_FILL && c == cend) begin
            c <= lft < 0 ? 10'sd0 : lft;
            r <= r + 10'sd1;
          end else begin
            r <= r + dr; c <= c + dc;
          end
        end
        S_SNAP: begin
          pend_addr <= ptr[AW-1:0];
          if (ptr == (AW+1)'(CELLS)) begin
            state <= S_COPY;
            pend <= 1'b0;
            ptr <= '0;
          end else begin
            pend <= 1'b1;
            ptr <= ptr + 1'b1;
          end
        end
        S_COPY: begin
          // issue snapshot read for (r,c); write lands next cycle
          if (ptr[0]) begin
            pend <= 1'b0;
            state <= S_OUT;
          end else begin
            pend <= on_cv(trr, tcc);
            pend_addr <= addr_of(trr, tcc);
            if (on_cv(trr, tcc)) cnt <= cnt + 1'b1;
            if (walk_done) ptr[0] <= 1'b1;
            else if (c == cend) begin
              c <= lft < 0 ? 10'sd0 : lft;
              r <= r + 10'sd1;
            end else c <= c + 10'sd1;
          end
        end
        S_READ: begin
          state <= S_OUT;
          pix <= on_cv(r, c) ? crdata : 3'd0;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {1'b0, cnt, pix};
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/rde_checker.sv @@
// Port-level checks for raster_draw_engine_core, bound to the top level.
// Depends on raster_draw_engine_core ports only.
module rde_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic [55:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("command taken while result pending");
  a_shade: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4 && m_axis_tdata[15] == 1'b0)
    else $error("bad result shade");
  a_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready right after reset");
endmodule

bind raster_draw_engine_core rde_checker u_rde_checker (.*);
